// ----- rtl/core/tppcm_pkg.sv -----
// shared types, palette constants and small mapping functions for the pixel pair color mapper
package tppcm_pkg;

   // render mode register codes
   typedef enum logic [1:0] {
      MODE_ASCII = 2'd0,
      MODE_ANSI  = 2'd1,
      MODE_GREY  = 2'd2,
      MODE_CUBE  = 2'd3
   } mode_type;

   localparam int PAL_SIZE = 8;

   // eight color ansi palette, one array per channel
   localparam logic [7:0] PAL_RED   [PAL_SIZE] =
      '{8'h00, 8'hd0, 8'h10, 8'hf7, 8'h10, 8'hfb, 8'h10, 8'hf0};
   localparam logic [7:0] PAL_GREEN [PAL_SIZE] =
      '{8'h00, 8'h10, 8'he0, 8'hf5, 8'h10, 8'h3d, 8'hf0, 8'hf0};
   localparam logic [7:0] PAL_BLUE  [PAL_SIZE] =
      '{8'h00, 8'h10, 8'h10, 8'h3a, 8'hf0, 8'hf8, 8'hf0, 8'hf0};

   // ansi shortcut codes and limits
   localparam logic [7:0] ANSI_BLACK      = 8'd0;
   localparam logic [7:0] ANSI_WHITE      = 8'd7;
   localparam logic [7:0] DARK_LIMIT      = 8'd30;
   localparam logic [7:0] BRIGHT_LIMIT    = 8'd200;

   // grey ramp base
   localparam logic [7:0] GREY_BASE       = 8'd232;
   localparam logic [7:0] GREY_OFFSET     = 8'd231;
   localparam logic [7:0] CUBE_BASE       = 8'd16;

   // glyph ramp
   localparam int         GLYPH_COUNT     = 11;
   localparam int         GLYPH_DIVISOR   = 46;

   // reciprocal constants: x/3 ~ x*683>>11, x*10/103 ~ x*101810>>20
   localparam logic [20:0] RECIP_THIRD    = 21'd683;
   localparam logic [24:0] RECIP_GREY     = 25'd101810;

   // stage one: per channel products and cheap classifications
   typedef struct packed {
      logic [PAL_SIZE-1:0][2:0][15:0] prod;
      logic [9:0]                     top_sum;
      logic [9:0]                     bot_sum;
      logic [2:0][2:0]                top_lvl;
      logic [2:0][2:0]                bot_lvl;
      logic                           near_black;
      logic                           near_white;
   } stage1_type;

   // stage two: full distances, averages and cube codes
   typedef struct packed {
      logic [PAL_SIZE-1:0][17:0]      pal_dist;
      logic [7:0]                     top_avg;
      logic [7:0]                     bot_avg;
      logic [7:0]                     top_cube;
      logic [7:0]                     bot_cube;
      logic                           near_black;
      logic                           near_white;
   } stage2_type;

   // stage three: two argmin candidates plus finished codes
   typedef struct packed {
      logic [2:0]                     lo_idx;
      logic [17:0]                    lo_dist;
      logic [2:0]                     hi_idx;
      logic [17:0]                    hi_dist;
      logic [7:0]                     top_grey;
      logic [7:0]                     bot_grey;
      logic [7:0]                     top_cube;
      logic [7:0]                     bot_cube;
      logic [3:0]                     glyph;
      logic                           near_black;
      logic                           near_white;
   } stage3_type;

   function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
      return (a > b) ? (a - b) : (b - a);
   endfunction

   // floor(c*10/506) as a threshold count
   function automatic logic [2:0] cube_level(input logic [7:0] c);
      logic [2:0] lvl;
      lvl = 3'd0;
      if (c >= 8'd51)  lvl = 3'd1;
      if (c >= 8'd102) lvl = 3'd2;
      if (c >= 8'd152) lvl = 3'd3;
      if (c >= 8'd203) lvl = 3'd4;
      if (c >= 8'd253) lvl = 3'd5;
      return lvl;
   endfunction

   function automatic logic [7:0] cube_code(input logic [2:0][2:0] lvl);
      return CUBE_BASE + 8'(lvl[0]) * 8'd36 + 8'(lvl[1]) * 8'd6 + 8'(lvl[2]);
   endfunction

   // floor(sum/3) for sums up to 765
   function automatic logic [7:0] avg3(input logic [9:0] s);
      logic [20:0] m;
      m = 21'(s) * RECIP_THIRD;
      return m[18:11];
   endfunction

   // max(232, 231 + floor(a*10/103))
   function automatic logic [7:0] grey_code(input logic [7:0] a);
      logic [24:0] m;
      logic [4:0]  k;
      m = 25'(a) * RECIP_GREY;
      k = m[24:20];
      return (k == 5'd0) ? GREY_BASE : GREY_OFFSET + 8'(k);
   endfunction

   // floor(s/46) clamped to the last glyph
   function automatic logic [3:0] glyph_level(input logic [8:0] s);
      logic [3:0] g;
      g = 4'd0;
      for (int k = 1; k < GLYPH_COUNT; k++) begin
         if (s >= 9'(GLYPH_DIVISOR * k)) g = 4'(k);
      end
      return g;
   endfunction

endpackage

// ----- rtl/core/terminal_pixel_pair_color_mapper.sv -----
// pixel pair to terminal color code and glyph index mapper, four stage pipeline
//
//  channel   | ports                    | direction | handshake
//  ----------+--------------------------+-----------+-------------------------
//  request   | req_* six rgb channels   | in        | req_valid / req_ready
//  response  | rsp_* glyph, codes, vld  | out       | rsp_valid / rsp_ready
//  control   | csr_wr_en, csr_wr_data   | in        | write on csr_wr_en, no wait
//
// one item per clock sustained while rsp_ready is high; each item passes the four register
// stages in order: products, distance sums, argmin tree and grey/glyph scaling, final select
// into the output register
// synchronous active high reset empties the pipeline and sets the mode to ascii
// a stalled output holds each full stage that has no empty stage after it; the others move on
module terminal_pixel_pair_color_mapper (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic [1:0] csr_wr_data,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_top_red,
   input  logic [7:0] req_top_green,
   input  logic [7:0] req_top_blue,
   input  logic [7:0] req_bottom_red,
   input  logic [7:0] req_bottom_green,
   input  logic [7:0] req_bottom_blue,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [3:0] rsp_glyph_index,
   output logic [7:0] rsp_top_color,
   output logic [7:0] rsp_bottom_color,
   output logic       rsp_top_valid,
   output logic       rsp_bottom_valid
);

   tppcm_pkg::mode_type   mode_ff;
   tppcm_pkg::stage1_type s1_ff, s1_in;
   tppcm_pkg::stage2_type s2_ff, s2_in;
   tppcm_pkg::stage3_type s3_ff, s3_in;
   logic                  v1_ff, v2_ff, v3_ff, v4_ff;
   logic                  adv1, adv2, adv3, adv4;
   logic [3:0]            glyph_ff, glyph_in;
   logic [7:0]            top_ff, top_in, bot_ff, bot_in;
   logic                  tv_ff, tv_in, bv_ff, bv_in;
   logic [7:0]            chan [3];

   // mode register
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= tppcm_pkg::MODE_ASCII;
      end else if (csr_wr_en) begin
         mode_ff <= tppcm_pkg::mode_type'(csr_wr_data);
      end
   end

   // stage advance: a stage loads when it is empty or its contents move on
   assign adv4      = !v4_ff || rsp_ready;
   assign adv3      = !v3_ff || adv4;
   assign adv2      = !v2_ff || adv3;
   assign adv1      = !v1_ff || adv2;
   assign req_ready = adv1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (adv1) v1_ff <= req_valid;
         if (adv2) v2_ff <= v1_ff;
         if (adv3) v3_ff <= v2_ff;
         if (adv4) v4_ff <= v3_ff;
      end
   end

   // stage one: |pal - c| * c for every palette entry and channel
   assign chan[0] = req_top_red;
   assign chan[1] = req_top_green;
   assign chan[2] = req_top_blue;

   always_comb begin
      for (int i = 0; i < tppcm_pkg::PAL_SIZE; i++) begin
         s1_in.prod[i][0] = 16'(tppcm_pkg::abs_diff(tppcm_pkg::PAL_RED[i], chan[0]))
                            * 16'(chan[0]);
         s1_in.prod[i][1] = 16'(tppcm_pkg::abs_diff(tppcm_pkg::PAL_GREEN[i], chan[1]))
                            * 16'(chan[1]);
         s1_in.prod[i][2] = 16'(tppcm_pkg::abs_diff(tppcm_pkg::PAL_BLUE[i], chan[2]))
                            * 16'(chan[2]);
      end
      s1_in.top_sum    = 10'(req_top_red) + 10'(req_top_green) + 10'(req_top_blue);
      s1_in.bot_sum    = 10'(req_bottom_red) + 10'(req_bottom_green)
                         + 10'(req_bottom_blue);
      s1_in.top_lvl[0] = tppcm_pkg::cube_level(req_top_red);
      s1_in.top_lvl[1] = tppcm_pkg::cube_level(req_top_green);
      s1_in.top_lvl[2] = tppcm_pkg::cube_level(req_top_blue);
      s1_in.bot_lvl[0] = tppcm_pkg::cube_level(req_bottom_red);
      s1_in.bot_lvl[1] = tppcm_pkg::cube_level(req_bottom_green);
      s1_in.bot_lvl[2] = tppcm_pkg::cube_level(req_bottom_blue);
      s1_in.near_black = (req_top_red < tppcm_pkg::DARK_LIMIT)
                         && (req_top_green < tppcm_pkg::DARK_LIMIT)
                         && (req_top_blue < tppcm_pkg::DARK_LIMIT);
      s1_in.near_white = (req_top_red > tppcm_pkg::BRIGHT_LIMIT)
                         && (req_top_green > tppcm_pkg::BRIGHT_LIMIT)
                         && (req_top_blue > tppcm_pkg::BRIGHT_LIMIT);
   end

   always_ff @(posedge clock) begin
      if (adv1) s1_ff <= s1_in;
   end

   // stage two: distance sums, channel averages, cube codes
   always_comb begin
      for (int i = 0; i < tppcm_pkg::PAL_SIZE; i++) begin
         s2_in.pal_dist[i] = 18'(s1_ff.prod[i][0]) + 18'(s1_ff.prod[i][1])
                             + 18'(s1_ff.prod[i][2]);
      end
      s2_in.top_avg    = tppcm_pkg::avg3(s1_ff.top_sum);
      s2_in.bot_avg    = tppcm_pkg::avg3(s1_ff.bot_sum);
      s2_in.top_cube   = tppcm_pkg::cube_code(s1_ff.top_lvl);
      s2_in.bot_cube   = tppcm_pkg::cube_code(s1_ff.bot_lvl);
      s2_in.near_black = s1_ff.near_black;
      s2_in.near_white = s1_ff.near_white;
   end

   always_ff @(posedge clock) begin
      if (adv2) s2_ff <= s2_in;
   end

   // stage three: argmin tree down to two candidates, grey codes, glyph
   logic [3:0][2:0]  pair_idx;
   logic [3:0][17:0] pair_dist;

   always_comb begin
      // the higher index wins only on a strictly smaller distance
      for (int j = 0; j < 4; j++) begin
         if (s2_ff.pal_dist[2*j+1] < s2_ff.pal_dist[2*j]) begin
            pair_idx[j]  = 3'(2*j+1);
            pair_dist[j] = s2_ff.pal_dist[2*j+1];
         end else begin
            pair_idx[j]  = 3'(2*j);
            pair_dist[j] = s2_ff.pal_dist[2*j];
         end
      end
      if (pair_dist[1] < pair_dist[0]) begin
         s3_in.lo_idx  = pair_idx[1];
         s3_in.lo_dist = pair_dist[1];
      end else begin
         s3_in.lo_idx  = pair_idx[0];
         s3_in.lo_dist = pair_dist[0];
      end
      if (pair_dist[3] < pair_dist[2]) begin
         s3_in.hi_idx  = pair_idx[3];
         s3_in.hi_dist = pair_dist[3];
      end else begin
         s3_in.hi_idx  = pair_idx[2];
         s3_in.hi_dist = pair_dist[2];
      end
      s3_in.top_grey   = tppcm_pkg::grey_code(s2_ff.top_avg);
      s3_in.bot_grey   = tppcm_pkg::grey_code(s2_ff.bot_avg);
      s3_in.glyph      = tppcm_pkg::glyph_level(9'(s2_ff.top_avg) + 9'(s2_ff.bot_avg));
      s3_in.top_cube   = s2_ff.top_cube;
      s3_in.bot_cube   = s2_ff.bot_cube;
      s3_in.near_black = s2_ff.near_black;
      s3_in.near_white = s2_ff.near_white;
   end

   always_ff @(posedge clock) begin
      if (adv3) s3_ff <= s3_in;
   end

   // stage four: last argmin step and mode select into the output register
   logic [7:0] ansi_code;

   always_comb begin
      if (s3_ff.near_black) begin
         ansi_code = tppcm_pkg::ANSI_BLACK;
      end else if (s3_ff.near_white) begin
         ansi_code = tppcm_pkg::ANSI_WHITE;
      end else if (s3_ff.hi_dist < s3_ff.lo_dist) begin
         ansi_code = 8'(s3_ff.hi_idx);
      end else begin
         ansi_code = 8'(s3_ff.lo_idx);
      end

      glyph_in = s3_ff.glyph;
      top_in   = 8'd0;
      bot_in   = 8'd0;
      tv_in    = 1'b0;
      bv_in    = 1'b0;
      case (mode_ff)
         tppcm_pkg::MODE_ANSI: begin
            top_in = ansi_code;
            tv_in  = 1'b1;
         end
         tppcm_pkg::MODE_GREY: begin
            top_in = s3_ff.top_grey;
            bot_in = s3_ff.bot_grey;
            tv_in  = 1'b1;
            bv_in  = 1'b1;
         end
         tppcm_pkg::MODE_CUBE: begin
            top_in = s3_ff.top_cube;
            bot_in = s3_ff.bot_cube;
            tv_in  = 1'b1;
            bv_in  = 1'b1;
         end
         default: begin
            top_in = 8'd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv4) begin
         glyph_ff <= glyph_in;
         top_ff   <= top_in;
         bot_ff   <= bot_in;
         tv_ff    <= tv_in;
         bv_ff    <= bv_in;
      end
   end

   assign rsp_valid        = v4_ff;
   assign rsp_glyph_index  = glyph_ff;
   assign rsp_top_color    = top_ff;
   assign rsp_bottom_color = bot_ff;
   assign rsp_top_valid    = tv_ff;
   assign rsp_bottom_valid = bv_ff;

   // checks on the result item
   a_glyph_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_glyph_index <= 4'd10)
      else $error("glyph index beyond ramp");

   a_top_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_top_valid |-> rsp_top_color == 8'd0 && rsp_bottom_color == 8'd0)
      else $error("color code set in ascii mode");

   a_bottom_implies_top: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bottom_valid |-> rsp_top_valid && rsp_bottom_color >= 8'd16)
      else $error("bottom code without top code or below cube range");

   a_ansi_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_top_valid && !rsp_bottom_valid |-> rsp_top_color <= 8'd7)
      else $error("ansi code beyond palette");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !v1_ff && !v2_ff && !v3_ff && !v4_ff |-> req_ready)
      else $error("empty pipeline refuses an item");

endmodule
